### rtl/core/dlr_pkg.sv
// Package for the DDA line rasterizer core.
// Holds default widths, the request kind codes and the sequencer state type.
// No dependencies.
`default_nettype none

package dlr_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COLOR_W        = 32;

   // request kind codes
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_EMIT
   } state_type;

endpackage : dlr_pkg

`default_nettype wire

### rtl/core/dlr_divider.sv
// Iterative restoring divider: (dividend << FRAC_BITS) / divisor, one quotient
// bit per cycle, for dividend <= divisor. Uses dlr_pkg.
// Result is FRAC_BITS+1 bits; done pulses when the last bit is registered.
`default_nettype none

module dlr_divider
   import dlr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0] divisor,
   output logic                  done,
   output logic [FRAC_BITS:0]    quotient
);

   localparam int REM_W = COORD_BITS + 1;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [REM_W-1:0]      rem_in;
   logic [COORD_BITS-1:0] divisor_ff;
   logic [Q_W-1:0]        quot_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [REM_W-1:0]      diff;
   logic                  ge;

   assign diff = rem_ff - {1'b0, divisor_ff};
   assign ge   = (rem_ff >= {1'b0, divisor_ff});

   // remainder stays below the divisor after a subtract, so the shift fits
   assign rem_in = ge ? {diff[REM_W-2:0], 1'b0} : {rem_ff[REM_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (count_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (count_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= {1'b0, dividend};
         divisor_ff <= divisor;
         quot_ff    <= '0;
         count_ff   <= CNT_W'(FRAC_BITS);
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         quot_ff  <= {quot_ff[Q_W-2:0], ge};
         count_ff <= count_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule : dlr_divider

`default_nettype wire

### rtl/core/dda_line_rasterizer_core.sv
// DDA line rasterizer core: top level with sequencer and position datapath.
// Uses dlr_pkg and dlr_divider.
//
// Usage: a start request (req_kind = 0) carries two endpoints and a color.
// The core computes steps = max(|dx|, |dy|) and the per-step increments
// dx/steps and dy/steps in fixed point with FRAC_BITS fraction bits, then
// returns the start pixel. Each step request (req_kind = 1) advances the
// position by one increment and returns the next pixel, rounded half away
// from zero. A line yields steps+1 pixels; the last has rsp_last_pixel set.
// A step request with no active line is taken and gives no response.
// A step request's pixel appears in the cycle after it is taken, and step
// requests are taken one per cycle while rsp_stall does not hold a response.
// A start request runs the shared serial divider twice, one quotient bit per
// cycle, first for the x and then for the y increment; req_stall stays high
// meanwhile. A zero-length line answers in the cycle after it is taken.
// Reset (synchronous, active high) drops any line and empties the response
// register. While the receiver holds rsp_stall, the response register holds
// its pixel and the core takes no new request.
`default_nettype none

module dda_line_rasterizer_core
   import dlr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic [COLOR_W-1:0]           req_pen_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_W-1:0]           rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   localparam int POS_W = COORD_BITS + FRAC_BITS + 1;
   localparam int INC_W = FRAC_BITS + 2;
   localparam int HALF  = 1 << (FRAC_BITS - 1);

   state_type state_ff;
   state_type state_in;

   logic signed [POS_W-1:0]      pos_x_ff;
   logic signed [POS_W-1:0]      pos_y_ff;
   logic signed [INC_W-1:0]      inc_x_ff;
   logic signed [INC_W-1:0]      inc_y_ff;
   logic [COORD_BITS-1:0]        steps_left_ff;
   logic [COORD_BITS-1:0]        abs_dy_ff;
   logic                         neg_x_ff;
   logic                         neg_y_ff;
   logic [COLOR_W-1:0]           color_ff;
   logic                         active_ff;

   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] pixel_x_ff;
   logic signed [COORD_BITS-1:0] pixel_y_ff;
   logic [COLOR_W-1:0]           pixel_color_ff;
   logic                         last_pixel_ff;

   logic                         rsp_free;
   logic                         req_accept;
   logic                         start_acc;
   logic                         step_acc;
   logic [COORD_BITS:0]          dx;
   logic [COORD_BITS:0]          dy;
   logic [COORD_BITS-1:0]        abs_dx;
   logic [COORD_BITS-1:0]        abs_dy;
   logic [COORD_BITS-1:0]        steps;
   logic                         zero_len;

   logic                         div_start;
   logic [COORD_BITS-1:0]        div_dividend;
   logic                         div_done;
   logic [FRAC_BITS:0]           div_quot;
   logic [INC_W-1:0]             quot_ext;
   logic signed [INC_W-1:0]      inc_from_x;
   logic signed [INC_W-1:0]      inc_from_y;

   logic signed [POS_W-1:0]      pos_x_next;
   logic signed [POS_W-1:0]      pos_y_next;

   logic                         load_rsp;
   logic signed [COORD_BITS-1:0] rsp_x_in;
   logic signed [COORD_BITS-1:0] rsp_y_in;
   logic                         rsp_last_in;

   // round half away from zero: bias by one half, one less for negatives
   function automatic logic signed [COORD_BITS-1:0] round_pos(
      input logic signed [POS_W-1:0] v
   );
      logic [POS_W-1:0] bias;
      logic [POS_W-1:0] sum;
      bias = v[POS_W-1] ? POS_W'(HALF - 1) : POS_W'(HALF);
      sum  = v + bias;
      return sum[FRAC_BITS +: COORD_BITS];
   endfunction

   // ---------------- start request decode ----------------
   assign dx = {req_end_x[COORD_BITS-1], req_end_x}
             - {req_start_x[COORD_BITS-1], req_start_x};
   assign dy = {req_end_y[COORD_BITS-1], req_end_y}
             - {req_start_y[COORD_BITS-1], req_start_y};
   assign abs_dx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
   assign abs_dy   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
   assign steps    = (abs_dx > abs_dy) ? abs_dx : abs_dy;
   assign zero_len = (steps == '0);

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign start_acc  = req_accept && (req_kind == KIND_START);
   assign step_acc   = req_accept && (req_kind == KIND_STEP) && active_ff;

   // ---------------- shared divider ----------------
   dlr_divider #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (state_ff == ST_IDLE ? steps : steps_left_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign quot_ext   = {1'b0, div_quot};
   assign inc_from_x = neg_x_ff ? (INC_W'(0) - quot_ext) : quot_ext;
   assign inc_from_y = neg_y_ff ? (INC_W'(0) - quot_ext) : quot_ext;

   assign pos_x_next = pos_x_ff + {{(POS_W - INC_W){inc_x_ff[INC_W-1]}}, inc_x_ff};
   assign pos_y_next = pos_y_ff + {{(POS_W - INC_W){inc_y_ff[INC_W-1]}}, inc_y_ff};

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_acc && !zero_len) begin
               state_in = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      div_dividend = abs_dx;
      load_rsp     = 1'b0;
      rsp_x_in     = req_start_x;
      rsp_y_in     = req_start_y;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !rsp_free;
            if (start_acc) begin
               if (zero_len) begin
                  load_rsp    = 1'b1;
                  rsp_last_in = 1'b1;
               end else begin
                  div_start = 1'b1;
               end
            end else if (step_acc) begin
               load_rsp    = 1'b1;
               rsp_x_in    = round_pos(pos_x_next);
               rsp_y_in    = round_pos(pos_y_next);
               rsp_last_in = (steps_left_ff == COORD_BITS'(1));
            end
         end
         ST_DIV_X: begin
            div_start    = div_done;
            div_dividend = abs_dy_ff;
         end
         ST_DIV_Y: begin
            div_dividend = abs_dy_ff;
         end
         ST_EMIT: begin
            load_rsp = rsp_free;
            rsp_x_in = round_pos(pos_x_ff);
            rsp_y_in = round_pos(pos_y_ff);
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_acc) begin
            active_ff <= !zero_len;
         end else if (step_acc && (steps_left_ff == COORD_BITS'(1))) begin
            active_ff <= 1'b0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- line state and response payload ----------------
   always_ff @(posedge clock) begin
      if (start_acc) begin
         color_ff      <= req_pen_color;
         pos_x_ff      <= {req_start_x[COORD_BITS-1], req_start_x, {FRAC_BITS{1'b0}}};
         pos_y_ff      <= {req_start_y[COORD_BITS-1], req_start_y, {FRAC_BITS{1'b0}}};
         steps_left_ff <= steps;
         abs_dy_ff     <= abs_dy;
         neg_x_ff      <= dx[COORD_BITS];
         neg_y_ff      <= dy[COORD_BITS];
         inc_x_ff      <= '0;
         inc_y_ff      <= '0;
      end else if (step_acc) begin
         pos_x_ff      <= pos_x_next;
         pos_y_ff      <= pos_y_next;
         steps_left_ff <= steps_left_ff - 1'b1;
      end else if (div_done && (state_ff == ST_DIV_X)) begin
         inc_x_ff <= inc_from_x;
      end else if (div_done && (state_ff == ST_DIV_Y)) begin
         inc_y_ff <= inc_from_y;
      end

      if (load_rsp) begin
         pixel_x_ff     <= rsp_x_in;
         pixel_y_ff     <= rsp_y_in;
         pixel_color_ff <= start_acc ? req_pen_color : color_ff;
         last_pixel_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_last_pixel  = last_pixel_ff;

   // ---------------- assertions ----------------
   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (steps_left_ff != '0))
      else $error("active line with no steps left");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_X || state_ff == ST_DIV_Y))
      else $error("divider finished outside a divide state");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && rsp_last_in) |=> !active_ff)
      else $error("line still active after its last pixel");

   a_busy_has_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> active_ff)
      else $error("sequencer busy without an active line");

endmodule : dda_line_rasterizer_core

`default_nettype wire
